// File: rtl/llag_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and rule tables for the Life-like generation block.
// Used by llag_lane, llag_merge and life_like_automaton_generation.
package llag_pkg;

    localparam int CELL_W    = 32;
    localparam int ROW_NUM_W = 5;
    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 1;
    localparam int RULE_W    = 3;
    localparam int COUNT_W   = 9;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_RULE_SET     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'b1;

    // Rule set codes
    localparam logic [RULE_W-1:0] RULE_B3_S23         = 3'd0;
    localparam logic [RULE_W-1:0] RULE_B35_S236       = 3'd1;
    localparam logic [RULE_W-1:0] RULE_B357_S1358     = 3'd2;
    localparam logic [RULE_W-1:0] RULE_B378_S235678   = 3'd3;
    localparam logic [RULE_W-1:0] RULE_B25678_S5678   = 3'd4;

    typedef struct packed {
        logic [CELL_W-1:0] row_cells;
        logic              last_row;
    } row_word_t;

    typedef struct packed {
        logic [CELL_W-1:0]    next_cells;
        logic [CELL_W-1:0]    born_cells;
        logic [ROW_NUM_W-1:0] row_number;
        logic                 final_row;
    } gen_word_t;

    // Bit k set: a neighbor count of k gives birth / survival
    typedef struct packed {
        logic [COUNT_W-1:0] birth;
        logic [COUNT_W-1:0] survive;
    } rule_t;

    // Three-cell slices of the rows above, at and below one column;
    // bit 0 is the left column, bit 1 the column itself, bit 2 the right
    typedef struct packed {
        logic [2:0] up;
        logic [2:0] mid;
        logic [2:0] dn;
    } nbhd_t;

    typedef struct packed {
        logic [CELL_W-1:0] next_cells;
        logic [CELL_W-1:0] born_cells;
    } row_result_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_PRIME,
        ST_EMIT
    } gen_state_t;

    function automatic rule_t rule_masks(input logic [RULE_W-1:0] sel);
        rule_t r;
        case (sel)
            RULE_B3_S23:       r = '{birth: 9'h008, survive: 9'h00C};
            RULE_B35_S236:     r = '{birth: 9'h028, survive: 9'h04C};
            RULE_B357_S1358:   r = '{birth: 9'h0A8, survive: 9'h12A};
            RULE_B378_S235678: r = '{birth: 9'h188, survive: 9'h1EC};
            RULE_B25678_S5678: r = '{birth: 9'h1E4, survive: 9'h1E0};
            default:           r = '{birth: 9'h000, survive: 9'h000};
        endcase
        return r;
    endfunction

endpackage

// File: rtl/llag_lane.sv
`timescale 1ns / 1ps
// One cell lane: counts the eight neighbors and applies the birth/survival rule.
// Depends on llag_pkg for the neighborhood and rule types.
module llag_lane (
    input  llag_pkg::nbhd_t nbhd,
    input  llag_pkg::rule_t rule,
    output logic            next_cell
);

    logic [3:0] count;

    assign count = 4'(nbhd.up[0]) + 4'(nbhd.up[1]) + 4'(nbhd.up[2])
                 + 4'(nbhd.mid[0]) + 4'(nbhd.mid[2])
                 + 4'(nbhd.dn[0]) + 4'(nbhd.dn[1]) + 4'(nbhd.dn[2]);

    // Count never exceeds eight, so it always lands inside the mask
    assign next_cell = nbhd.mid[1] ? rule.survive[count] : rule.birth[count];

endmodule

// File: rtl/llag_merge.sv
`timescale 1ns / 1ps
// Merges the lane results into one output row and its mask of born cells.
// Depends on llag_pkg for the row result type.
module llag_merge (
    input  logic [llag_pkg::CELL_W-1:0] lane_bits,
    input  logic [llag_pkg::CELL_W-1:0] old_row,
    input  logic [llag_pkg::CELL_W-1:0] width_mask,
    output llag_pkg::row_result_t       result
);

    logic [llag_pkg::CELL_W-1:0] next_row;

    // Drop lanes past the column count in use
    assign next_row          = lane_bits & width_mask;
    assign result.next_cells = next_row;
    assign result.born_cells = next_row & ~old_row & width_mask;

endmodule

// File: rtl/life_like_automaton_generation.sv
`timescale 1ns / 1ps
// Life-like automaton generation: rows load one per cycle while in the load state; the
// row marked last starts the generation, which primes the three-row window and then
// registers one result row per cycle while gen_ready holds; no rows are taken until the
// frame is out. The single read port of the grid memory feeds the three-row window.
// Reset clears control registers, sets rule B3/S23 and 32 columns; grid memory stays undefined.
module life_like_automaton_generation #(
    parameter int MAX_COLUMNS = 32,
    parameter int MAX_ROWS    = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           row_valid,
    output logic                           row_ready,
    input  llag_pkg::row_word_t            row_word,
    output logic                           gen_valid,
    input  logic                           gen_ready,
    output llag_pkg::gen_word_t            gen_word,
    input  logic                           cfg_we,
    input  logic [llag_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [llag_pkg::CFG_W-1:0]     cfg_data
);

    localparam int COL_CAP = (MAX_COLUMNS < llag_pkg::CELL_W) ? MAX_COLUMNS : llag_pkg::CELL_W;
    localparam int ROW_CAP = (MAX_ROWS < llag_pkg::CELL_W) ? MAX_ROWS : llag_pkg::CELL_W;
    localparam int ROW_AW  = $clog2(ROW_CAP);
    localparam int CNT_W   = $clog2(ROW_CAP + 1);
    localparam int CW      = llag_pkg::CELL_W;
    localparam int CFG_W   = llag_pkg::CFG_W;
    localparam int RNW     = llag_pkg::ROW_NUM_W;
    localparam int ROW_NUM_W_SEL = 5;

    localparam logic [CNT_W-1:0] RowCap = CNT_W'(ROW_CAP);
    localparam logic [CFG_W-1:0] ColCap = CFG_W'(COL_CAP);

    // Configuration
    logic [llag_pkg::RULE_W-1:0] rule_set_reg;
    logic [CFG_W-1:0]            column_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rule_set_reg     <= llag_pkg::RULE_B3_S23;
            column_count_reg <= CFG_W'(32);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                llag_pkg::REG_RULE_SET:     rule_set_reg     <= cfg_data[llag_pkg::RULE_W-1:0];
                llag_pkg::REG_COLUMN_COUNT: column_count_reg <= cfg_data;
                default:                    ;
            endcase
        end
    end

    // Width in use, clamped to 1..COL_CAP
    logic [CFG_W-1:0] eff_w;
    logic [CFG_W-1:0] eff_w_m1;
    logic [CW-1:0]    width_mask;

    always_comb
    begin
        if (column_count_reg == '0)
            eff_w = CFG_W'(1);
        else if (column_count_reg > ColCap)
            eff_w = ColCap;
        else
            eff_w = column_count_reg;
    end

    assign eff_w_m1 = eff_w - CFG_W'(1);

    genvar m;
    generate
        for (m = 0; m < CW; m++)
        begin : g_mask
            assign width_mask[m] = (CFG_W'(m) < eff_w);
        end
    endgenerate

    llag_pkg::rule_t rule;
    assign rule = llag_pkg::rule_masks(rule_set_reg);

    // Control state
    llag_pkg::gen_state_t state_reg, state_next;
    logic [CNT_W-1:0]     rows_received_reg, rows_received_next;
    logic [ROW_AW-1:0]    rd_addr_reg, rd_addr_next;
    logic [ROW_AW-1:0]    y_reg, y_next;
    logic [1:0]           prime_cnt_reg, prime_cnt_next;
    logic                 gen_valid_reg, gen_valid_next;

    // Datapath
    logic [CW-1:0]        grid_mem [ROW_CAP];
    logic [CW-1:0]        up_reg, mid_reg, dn_reg, mem_q_reg;
    llag_pkg::gen_word_t  gen_word_reg;

    logic                 accept;
    logic                 store;
    logic                 shift;
    logic                 advance;
    logic                 last_y;
    logic [CNT_W-1:0]     h_new;
    logic [CNT_W-1:0]     rd_inc;

    assign accept = row_valid && row_ready;
    assign store  = accept && (rows_received_reg < RowCap);
    assign h_new  = rows_received_reg + CNT_W'(store);
    assign rd_inc = CNT_W'(rd_addr_reg) + CNT_W'(1);
    assign last_y = (CNT_W'(y_reg) + CNT_W'(1)) == rows_received_reg;

    always_comb
    begin
        state_next         = state_reg;
        rows_received_next = rows_received_reg;
        rd_addr_next       = rd_addr_reg;
        y_next             = y_reg;
        prime_cnt_next     = prime_cnt_reg;
        row_ready          = 1'b0;
        shift              = 1'b0;
        advance            = 1'b0;

        case (state_reg)
            llag_pkg::ST_LOAD:
            begin
                row_ready = 1'b1;
                if (accept)
                begin
                    rows_received_next = h_new;
                    if (row_word.last_row)
                    begin
                        // Window starts on the row above row zero
                        rd_addr_next   = ROW_AW'(h_new - CNT_W'(1));
                        prime_cnt_next = 2'd0;
                        state_next     = llag_pkg::ST_PRIME;
                    end
                end
            end
            llag_pkg::ST_PRIME:
            begin
                shift          = 1'b1;
                prime_cnt_next = prime_cnt_reg + 2'd1;
                if (prime_cnt_reg == 2'd3)
                begin
                    y_next     = '0;
                    state_next = llag_pkg::ST_EMIT;
                end
            end
            llag_pkg::ST_EMIT:
            begin
                advance = !gen_valid_reg || gen_ready;
                shift   = advance;
                if (advance)
                begin
                    if (last_y)
                    begin
                        rows_received_next = '0;
                        state_next         = llag_pkg::ST_LOAD;
                    end
                    else
                        y_next = y_reg + ROW_AW'(1);
                end
            end
            default:
                state_next = llag_pkg::ST_LOAD;
        endcase

        // Read pointer wraps at the row count of the frame
        if (shift)
            rd_addr_next = (rd_inc == rows_received_reg) ? '0 : ROW_AW'(rd_inc);

        if (advance)
            gen_valid_next = 1'b1;
        else if (gen_ready)
            gen_valid_next = 1'b0;
        else
            gen_valid_next = gen_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= llag_pkg::ST_LOAD;
            rows_received_reg <= '0;
            rd_addr_reg       <= '0;
            y_reg             <= '0;
            prime_cnt_reg     <= '0;
            gen_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            rows_received_reg <= rows_received_next;
            rd_addr_reg       <= rd_addr_next;
            y_reg             <= y_next;
            prime_cnt_reg     <= prime_cnt_next;
            gen_valid_reg     <= gen_valid_next;
        end
    end

    // Grid memory and the three-row window behind its read register
    always_ff @(posedge clk)
    begin
        if (store)
            grid_mem[rows_received_reg[ROW_AW-1:0]] <= row_word.row_cells & width_mask;
        if (shift)
        begin
            up_reg    <= mid_reg;
            mid_reg   <= dn_reg;
            dn_reg    <= mem_q_reg;
            mem_q_reg <= grid_mem[rd_addr_reg];
        end
    end

    // Cell lanes
    logic [CW-1:0] lane_bits;

    genvar c;
    generate
        for (c = 0; c < COL_CAP; c++)
        begin : g_lane
            logic            l_up, l_mid, l_dn;
            logic            r_up, r_mid, r_dn;
            llag_pkg::nbhd_t nbhd;

            if (c == 0)
            begin : g_left_wrap
                assign l_up  = up_reg[eff_w_m1[ROW_NUM_W_SEL-1:0]];
                assign l_mid = mid_reg[eff_w_m1[ROW_NUM_W_SEL-1:0]];
                assign l_dn  = dn_reg[eff_w_m1[ROW_NUM_W_SEL-1:0]];
            end
            else
            begin : g_left
                assign l_up  = up_reg[c-1];
                assign l_mid = mid_reg[c-1];
                assign l_dn  = dn_reg[c-1];
            end

            if (c == COL_CAP - 1)
            begin : g_right_edge
                assign r_up  = up_reg[0];
                assign r_mid = mid_reg[0];
                assign r_dn  = dn_reg[0];
            end
            else
            begin : g_right
                logic wrap;
                assign wrap  = (eff_w == CFG_W'(c + 1));
                assign r_up  = wrap ? up_reg[0]  : up_reg[c+1];
                assign r_mid = wrap ? mid_reg[0] : mid_reg[c+1];
                assign r_dn  = wrap ? dn_reg[0]  : dn_reg[c+1];
            end

            assign nbhd.up  = {r_up,  up_reg[c],  l_up};
            assign nbhd.mid = {r_mid, mid_reg[c], l_mid};
            assign nbhd.dn  = {r_dn,  dn_reg[c],  l_dn};

            llag_lane u_lane (
                .nbhd      (nbhd),
                .rule      (rule),
                .next_cell (lane_bits[c])
            );
        end

        if (COL_CAP < CW)
        begin : g_unused_lanes
            assign lane_bits[CW-1:COL_CAP] = '0;
        end
    endgenerate

    llag_pkg::row_result_t row_result;

    llag_merge u_merge (
        .lane_bits  (lane_bits),
        .old_row    (mid_reg),
        .width_mask (width_mask),
        .result     (row_result)
    );

    // Output register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            gen_word_reg.next_cells <= row_result.next_cells;
            gen_word_reg.born_cells <= row_result.born_cells;
            gen_word_reg.row_number <= RNW'(y_reg);
            gen_word_reg.final_row  <= last_y;
        end
    end

    assign gen_valid = gen_valid_reg;
    assign gen_word  = gen_word_reg;

`ifndef SYNTHESIS
    a_rows_capped: assert property (@(posedge clk) disable iff (!rst_n)
        rows_received_reg <= RowCap)
        else $error("rows held exceed capacity");

    a_emit_row_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == llag_pkg::ST_EMIT) |-> (CNT_W'(y_reg) < rows_received_reg))
        else $error("emitted row index past frame height");

    a_read_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != llag_pkg::ST_LOAD) |-> (CNT_W'(rd_addr_reg) < rows_received_reg))
        else $error("grid read address past frame height");

    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && last_y) |=> (gen_valid && gen_word.final_row && rows_received_reg == '0))
        else $error("frame did not close on its final row");
`endif

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Testbench for life_like_automaton_generation: frames of grid rows in, one generation out.
// Predicts each result row with its own torus model; depends on llag_pkg and the block.
module testbench;

    localparam int LIMIT_CYCLES = 200000;
    localparam int GRID_ROWS    = 32;
    localparam int GRID_COLS    = 32;
    localparam int SETTLE       = 12;
    localparam int LONG_HOLD    = 400;
    localparam int PHASE_ROWS   = 15;

    // rule codes with no birth and no survival
    localparam logic [llag_pkg::RULE_W-1:0] RULE_DEAD_LO = 3'd5;
    localparam logic [llag_pkg::RULE_W-1:0] RULE_DEAD_HI = 3'd7;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           row_valid = 1'b0;
    logic                           row_ready;
    llag_pkg::row_word_t            row_word  = '0;
    logic                           gen_valid;
    logic                           gen_ready = 1'b0;
    llag_pkg::gen_word_t            gen_word;
    logic                           cfg_we    = 1'b0;
    logic [llag_pkg::CFG_IDX_W-1:0] cfg_index = llag_pkg::REG_RULE_SET;
    logic [llag_pkg::CFG_W-1:0]     cfg_data  = '0;

    llag_pkg::row_word_t rows_pending[$];
    llag_pkg::gen_word_t gen_expected[$];

    // predictor copy of the grid, the row count and the registers
    logic [llag_pkg::CELL_W-1:0] grid_copy [GRID_ROWS];
    int                          rows_held  = 0;
    logic [llag_pkg::RULE_W-1:0] rule_now   = llag_pkg::RULE_B3_S23;
    logic [llag_pkg::CFG_W-1:0]  width_now  = 6'd32;

    int stall_pct       = 23;
    bit want_hold       = 1'b0;
    int hold_left       = 0;
    bit hold_used       = 1'b0;
    int errors          = 0;
    int rows_sent       = 0;
    int frames_done     = 0;
    int results_checked = 0;
    int cfg_writes      = 0;
    int cycles          = 0;

    life_like_automaton_generation uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .row_valid (row_valid),
        .row_ready (row_ready),
        .row_word  (row_word),
        .gen_valid (gen_valid),
        .gen_ready (gen_ready),
        .gen_word  (gen_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic bit next_alive(input logic [llag_pkg::RULE_W-1:0] rule, input bit alive,
                                      input int n);
        case (rule)
            llag_pkg::RULE_B3_S23:
                return alive ? (n == 2 || n == 3) : (n == 3);
            llag_pkg::RULE_B35_S236:
                return alive ? (n == 2 || n == 3 || n == 6) : (n == 3 || n == 5);
            llag_pkg::RULE_B357_S1358:
                return alive ? (n == 1 || n == 3 || n == 5 || n == 8)
                             : (n == 3 || n == 5 || n == 7);
            llag_pkg::RULE_B378_S235678:
                return alive ? (n == 2 || n == 3 || n >= 5) : (n == 3 || n == 7 || n == 8);
            llag_pkg::RULE_B25678_S5678:
                return alive ? (n >= 5) : (n == 2 || n >= 5);
            default:
                return 1'b0;
        endcase
    endfunction

    // Store one accepted row; on the last row compute the whole generation.
    function automatic void advance_grid(input llag_pkg::row_word_t w);
        int                          width;
        int                          height;
        int                          n;
        logic [llag_pkg::CELL_W-1:0] wmask;
        logic [llag_pkg::CELL_W-1:0] old;
        logic [llag_pkg::CELL_W-1:0] nxt;
        llag_pkg::gen_word_t         g;
        width = int'(width_now);
        if (width < 1)
            width = 1;
        if (width > GRID_COLS)
            width = GRID_COLS;
        wmask = (width >= 32) ? '1 : ((32'd1 << width) - 32'd1);
        // drop rows once the store is full
        if (rows_held < GRID_ROWS)
        begin
            grid_copy[rows_held] = w.row_cells & wmask;
            rows_held++;
        end
        if (!w.last_row)
            return;
        height = rows_held;
        for (int y = 0; y < height; y++)
        begin
            old = grid_copy[y];
            nxt = '0;
            for (int x = 0; x < width; x++)
            begin
                n = 0;
                // modulo wrap: a tiny grid may count one cell several times
                for (int dy = -1; dy <= 1; dy++)
                    for (int dx = -1; dx <= 1; dx++)
                        if (dx != 0 || dy != 0)
                            n += grid_copy[(y + height + dy) % height][(x + width + dx) % width];
                nxt[x] = next_alive(rule_now, old[x], n);
            end
            g.next_cells = nxt & wmask;
            g.born_cells = nxt & ~old & wmask;
            g.row_number = llag_pkg::ROW_NUM_W'(y);
            g.final_row  = (y == height - 1);
            gen_expected.push_back(g);
        end
        rows_held = 0;
        frames_done++;
    endfunction

    function automatic void compare_field(input string field,
                                          input logic [llag_pkg::CELL_W-1:0] want,
                                          input logic [llag_pkg::CELL_W-1:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
        end
    endfunction

    // Row driver: offer the next pending word, idling at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid <= 1'b0;
            row_word  <= '0;
        end
        else
        begin
            if (row_valid && row_ready)
            begin
                advance_grid(row_word);
                rows_sent++;
            end
            if (!row_valid || row_ready)
            begin
                if (rows_pending.size() != 0 && $urandom_range(99) >= stall_pct)
                begin
                    row_valid <= 1'b1;
                    row_word  <= rows_pending.pop_front();
                end
                else
                    row_valid <= 1'b0;
            end
        end
    end

    // Result monitor: check each accepted word against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        llag_pkg::gen_word_t want;
        if (!rst_n)
        begin
            gen_ready <= 1'b0;
            hold_left = 0;
            hold_used = 1'b0;
        end
        else
        begin
            if (gen_valid && gen_ready)
            begin
                if (gen_expected.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, got %h",
                             $time, gen_word);
                end
                else
                begin
                    want = gen_expected.pop_front();
                    results_checked++;
                    compare_field("next_cells", want.next_cells, gen_word.next_cells);
                    compare_field("born_cells", want.born_cells, gen_word.born_cells);
                    compare_field("row_number", want.row_number, gen_word.row_number);
                    compare_field("final_row", want.final_row, gen_word.final_row);
                end
            end
            // hold off once for a long stretch so the block backs up
            if (want_hold && !hold_used && gen_valid)
            begin
                hold_used = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                gen_ready <= 1'b0;
            end
            else
                gen_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    task automatic write_reg(input logic [llag_pkg::CFG_IDX_W-1:0] idx,
                             input logic [llag_pkg::CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == llag_pkg::REG_RULE_SET)
            rule_now = val[llag_pkg::RULE_W-1:0];
        else
            width_now = val;
        cfg_writes++;
    endtask

    // Upper bits of the rule write are junk the block must ignore.
    task automatic set_config(input logic [llag_pkg::RULE_W-1:0] rule,
                              input logic [llag_pkg::CFG_W-1:0] width);
        write_reg(llag_pkg::REG_RULE_SET, {3'($urandom_range(7)), rule});
        write_reg(llag_pkg::REG_COLUMN_COUNT, width);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (rows_pending.size() != 0 || row_valid || gen_expected.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic push_row(input logic [llag_pkg::CELL_W-1:0] cells, input bit last);
        llag_pkg::row_word_t w;
        w.row_cells = cells;
        w.last_row  = last;
        rows_pending.push_back(w);
    endtask

    function automatic logic [llag_pkg::CELL_W-1:0] random_cells();
        case ($urandom_range(3))
            0:       return $urandom & $urandom;
            1:       return $urandom | $urandom;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_frame(input int height);
        for (int r = 0; r < height; r++)
            push_row(random_cells(), r == height - 1);
    endtask

    function automatic int pick_height();
        int p;
        p = $urandom_range(99);
        if (p < 70)
            return $urandom_range(6, 1);
        if (p < 93)
            return $urandom_range(32, 7);
        return $urandom_range(36, 33);
    endfunction

    function automatic logic [llag_pkg::CFG_W-1:0] pick_width();
        if ($urandom_range(3) != 0)
            return 6'($urandom_range(32, 1));
        case ($urandom_range(5))
            0:       return 6'd0;
            1:       return 6'd1;
            2:       return 6'd2;
            3:       return 6'd33;
            4:       return 6'd63;
            default: return 6'd32;
        endcase
    endfunction

    initial
    begin
        int                          filled;
        int                          height;
        logic [llag_pkg::RULE_W-1:0] rule;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: single full row, a blinker, wrap across the column edge
        push_row('1, 1'b1);
        push_row('0, 1'b0);
        push_row(32'h0000_000E, 1'b0);
        push_row('0, 1'b0);
        push_row('0, 1'b1);
        push_row('1, 1'b0);
        push_row(32'h8000_0001, 1'b0);
        push_row('0, 1'b1);
        wait_idle();

        // width zero acts as one; bits past the width are dropped
        set_config(llag_pkg::RULE_B35_S236, 6'd0);
        push_row('1, 1'b0);
        push_row(32'hAAAA_AAAA, 1'b1);
        wait_idle();

        set_config(llag_pkg::RULE_B357_S1358, 6'd63);
        push_frame(3);
        wait_idle();

        set_config(llag_pkg::RULE_B378_S235678, 6'd3);
        push_row('1, 1'b0);
        push_row(32'h5555_5555, 1'b0);
        push_row(32'hFFFF_FFF8, 1'b1);
        wait_idle();

        set_config(llag_pkg::RULE_B25678_S5678, 6'd5);
        push_frame(4);
        wait_idle();

        // rule codes past the table: every cell dies
        set_config(RULE_DEAD_LO, 6'd32);
        push_row('1, 1'b0);
        push_row('1, 1'b1);
        wait_idle();

        set_config(RULE_DEAD_HI, 6'd1);
        push_row('1, 1'b1);
        wait_idle();

        // overflow: rows past the store are dropped, the last one still triggers
        set_config(llag_pkg::RULE_B3_S23, 6'd32);
        push_frame(GRID_ROWS + 2);
        wait_idle();

        for (int phase = 0; phase < 6; phase++)
        begin
            if ($urandom_range(99) < 85)
                rule = llag_pkg::RULE_W'($urandom_range(4));
            else
                rule = llag_pkg::RULE_W'($urandom_range(7, 5));
            set_config(rule, pick_width());
            stall_pct = (phase == 0) ? 0 : 23;
            if (phase == 2)
                want_hold = 1'b1;
            filled = 0;
            while (filled < PHASE_ROWS)
            begin
                height = pick_height();
                push_frame(height);
                filled += height;
            end
            wait_idle();
        end

        $display("covered %0d rows in %0d frames over %0d register writes,", rows_sent,
                 frames_done, cfg_writes);
        $display("all five rules, dead rule codes, widths 0 to 63, overflow; %0d rows checked",
                 results_checked);
        if (errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

// File: filelist.f
rtl/llag_pkg.sv
rtl/llag_lane.sv
rtl/llag_merge.sv
rtl/life_like_automaton_generation.sv
tb/sv/testbench.sv
